@@ sv/cbmt_pkg.sv @@
// ----------------------------------------------------------------------------
// cbmt_pkg
// Shared types, codes and defaults of the controller button map table.
// ----------------------------------------------------------------------------
package cbmt_pkg;

    localparam int CTRL_DEFAULT = 8;
    localparam int MAPS_DEFAULT = 64;
    localparam int RESULT_CAP   = 8;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MAP    = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic        used;
        logic [7:0]  button;
        logic [15:0] action;
    } entry_t;

    typedef struct packed {
        logic       load;
        logic       slot_start;
        logic       slot_write;
        logic       clear_start;
        logic       entry_start;
        logic       ent_wr;
        logic       ent_wr_used;
        logic       resp;
        logic [1:0] resp_status;
        logic       resp_action;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       limit_zero;
        logic       any_used;
        logic       slot_last;
        logic       slot_hit;
        logic       slot_free;
        logic       clear_last;
        logic       ent_last;
        logic       ent_hit;
        logic       ent_free;
    } stat_t;

endpackage

@@ sv/cbmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbmt_ctrl
// Request sequencer: dispatches each request and steps the datapath scans.
// ----------------------------------------------------------------------------
module cbmt_ctrl
    import cbmt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_DISPATCH  = 8'b0000_0010,
        S_SLOT      = 8'b0000_0100,
        S_SLOT_EVAL = 8'b0000_1000,
        S_CLEAR     = 8'b0001_0000,
        S_ENT       = 8'b0010_0000,
        S_ENT_EVAL  = 8'b0100_0000,
        S_LIST      = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_LIST)
                begin
                    if (stat.limit_zero)
                    begin
                        cmd.resp        = 1'b1;
                        cmd.resp_status = ST_UNKNOWN;
                        state_next      = S_IDLE;
                    end
                    else if (!stat.any_used)
                    begin
                        cmd.resp        = 1'b1;
                        cmd.resp_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.slot_start = 1'b1;
                        state_next     = S_LIST;
                    end
                end
                else if (stat.op == OP_ADD || stat.op == OP_MAP ||
                         stat.op == OP_GET || stat.op == OP_REMOVE)
                begin
                    cmd.slot_start = 1'b1;
                    state_next     = S_SLOT;
                end
                else
                begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = ST_UNKNOWN;
                    state_next      = S_IDLE;
                end
            end
            S_SLOT:
            begin
                if (stat.slot_last)
                begin
                    state_next = S_SLOT_EVAL;
                end
            end
            S_SLOT_EVAL:
            begin
                if (stat.op == OP_ADD)
                begin
                    if (stat.slot_hit)
                    begin
                        cmd.resp        = 1'b1;
                        cmd.resp_status = ST_REFUSED;
                        state_next      = S_IDLE;
                    end
                    else if (!stat.slot_free)
                    begin
                        cmd.resp        = 1'b1;
                        cmd.resp_status = ST_FULL;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.slot_write  = 1'b1;
                        cmd.clear_start = 1'b1;
                        state_next      = S_CLEAR;
                    end
                end
                else if (!stat.slot_hit)
                begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = ST_UNKNOWN;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.entry_start = 1'b1;
                    state_next      = S_ENT;
                end
            end
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_ENT:
            begin
                if (stat.ent_last)
                begin
                    state_next = S_ENT_EVAL;
                end
            end
            S_ENT_EVAL:
            begin
                cmd.resp   = 1'b1;
                state_next = S_IDLE;
                if (stat.op == OP_MAP)
                begin
                    if (stat.ent_hit || stat.ent_free)
                    begin
                        cmd.ent_wr      = 1'b1;
                        cmd.ent_wr_used = 1'b1;
                        cmd.resp_status = ST_OK;
                    end
                    else
                    begin
                        cmd.resp_status = ST_REFUSED;
                    end
                end
                else if (stat.ent_hit)
                begin
                    cmd.ent_wr      = (stat.op == OP_REMOVE);
                    cmd.resp_action = (stat.op == OP_GET);
                    cmd.resp_status = ST_OK;
                end
                else
                begin
                    cmd.resp_status = ST_REFUSED;
                end
            end
            S_LIST:
            begin
                if (stat.slot_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/cbmt_datapath.sv @@
// ----------------------------------------------------------------------------
// cbmt_datapath
// Slot table, entry memory, scan engines and result register.
// ----------------------------------------------------------------------------
module cbmt_datapath
    import cbmt_pkg::*;
#(
    parameter int CONTROLLERS         = CTRL_DEFAULT,
    parameter int MAPS_PER_CONTROLLER = MAPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  op,
    input  logic [15:0] ctrl_id,
    input  logic [7:0]  button,
    input  logic [15:0] action,
    input  logic [3:0]  list_limit,
    output logic        valid,
    output logic [1:0]  status,
    output logic [15:0] found_action,
    output logic [15:0] listed_id,
    output logic        id_valid,
    output logic        last
);

    localparam int DEPTH = CONTROLLERS * MAPS_PER_CONTROLLER;
    localparam int SW    = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
    localparam int EW    = (MAPS_PER_CONTROLLER > 1) ? $clog2(MAPS_PER_CONTROLLER) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(CONTROLLERS - 1);
    localparam logic [EW-1:0] LAST_ENT  = EW'(MAPS_PER_CONTROLLER - 1);
    localparam logic [3:0]    CAP       = 4'(RESULT_CAP);

    // request
    logic [2:0]  op_reg;
    logic [15:0] id_reg;
    logic [7:0]  button_reg;
    logic [15:0] action_reg;
    logic [3:0]  limit_reg;

    // slot table
    logic [CONTROLLERS-1:0] slot_used_reg;
    logic [15:0]            slot_id_mem [CONTROLLERS];

    // slot scan
    logic          sc_run_reg;
    logic [SW-1:0] sc_idx_reg;
    logic          sq_vld_reg;
    logic [SW-1:0] sq_idx_reg;
    logic          sq_used_reg;
    logic [15:0]   sq_id_reg;
    logic          shit_reg;
    logic [SW-1:0] shit_idx_reg;
    logic          sfree_reg;
    logic [SW-1:0] sfree_idx_reg;
    logic [3:0]    list_cnt_reg;
    logic          list_stop_reg;

    // entry memory and scans
    entry_t        entry_mem [DEPTH];
    logic [AW-1:0] base_reg;
    logic          ec_run_reg;
    logic [EW-1:0] ec_idx_reg;
    logic          eq_vld_reg;
    logic [EW-1:0] eq_idx_reg;
    entry_t        eq_data_reg;
    logic          ehit_reg;
    logic [EW-1:0] ehit_idx_reg;
    logic [15:0]   ehit_action_reg;
    logic          efree_reg;
    logic [EW-1:0] efree_idx_reg;
    logic          cl_run_reg;
    logic [EW-1:0] cl_idx_reg;

    // result
    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] found_action_reg;
    logic [15:0] listed_id_reg;
    logic        id_valid_reg;
    logic        last_reg;

    logic          s_hit;
    logic          list_emit;
    logic          list_last;
    logic          more_after;
    logic [3:0]    list_cap;
    logic          e_hit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            id_reg     <= ctrl_id;
            button_reg <= button;
            action_reg <= action;
            limit_reg  <= list_limit;
        end
    end

    // slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
        end
        else if (cmd.slot_write)
        begin
            slot_used_reg[sfree_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.slot_write)
        begin
            slot_id_mem[sfree_idx_reg] <= id_reg;
        end
        sq_id_reg   <= slot_id_mem[sc_idx_reg];
        sq_idx_reg  <= sc_idx_reg;
        sq_used_reg <= slot_used_reg[sc_idx_reg];
    end

    // slot scan
    always_comb
    begin
        more_after = 1'b0;
        for (int i = 0; i < CONTROLLERS; i++)
        begin
            if (SW'(i) > sq_idx_reg && slot_used_reg[i])
            begin
                more_after = 1'b1;
            end
        end
    end

    assign s_hit     = sq_vld_reg && sq_used_reg && (sq_id_reg == id_reg);
    assign list_cap  = (limit_reg > CAP) ? CAP : limit_reg;
    assign list_emit = sq_vld_reg && (op_reg == OP_LIST) && sq_used_reg && !list_stop_reg;
    assign list_last = ((list_cnt_reg + 4'd1) == list_cap) || !more_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_run_reg    <= 1'b0;
            sc_idx_reg    <= '0;
            sq_vld_reg    <= 1'b0;
            shit_reg      <= 1'b0;
            shit_idx_reg  <= '0;
            sfree_reg     <= 1'b0;
            sfree_idx_reg <= '0;
            list_cnt_reg  <= '0;
            list_stop_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= sc_run_reg;
            if (cmd.slot_start)
            begin
                sc_run_reg    <= 1'b1;
                sc_idx_reg    <= '0;
                shit_reg      <= 1'b0;
                sfree_reg     <= 1'b0;
                list_cnt_reg  <= '0;
                list_stop_reg <= 1'b0;
            end
            else
            begin
                if (sc_run_reg)
                begin
                    if (sc_idx_reg == LAST_SLOT)
                    begin
                        sc_run_reg <= 1'b0;
                    end
                    else
                    begin
                        sc_idx_reg <= sc_idx_reg + 1'b1;
                    end
                end
                if (s_hit && !shit_reg)
                begin
                    shit_reg     <= 1'b1;
                    shit_idx_reg <= sq_idx_reg;
                end
                if (sq_vld_reg && !sq_used_reg && !sfree_reg)
                begin
                    sfree_reg     <= 1'b1;
                    sfree_idx_reg <= sq_idx_reg;
                end
                if (list_emit)
                begin
                    list_cnt_reg  <= list_cnt_reg + 4'd1;
                    list_stop_reg <= list_last;
                end
            end
        end
    end

    // entry memory
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = base_reg + AW'(cl_idx_reg);
        mem_wdata = '0;
        if (cl_run_reg)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.ent_wr)
        begin
            mem_we           = 1'b1;
            mem_waddr        = base_reg + AW'(ehit_reg ? ehit_idx_reg : efree_idx_reg);
            mem_wdata.used   = cmd.ent_wr_used;
            mem_wdata.button = button_reg;
            mem_wdata.action = action_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        eq_data_reg <= entry_mem[base_reg + AW'(ec_idx_reg)];
        eq_idx_reg  <= ec_idx_reg;
    end

    assign e_hit = eq_vld_reg && eq_data_reg.used && (eq_data_reg.button == button_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.clear_start)
        begin
            base_reg <= AW'(sfree_idx_reg) * AW'(MAPS_PER_CONTROLLER);
        end
        else if (cmd.entry_start)
        begin
            base_reg <= AW'(shit_idx_reg) * AW'(MAPS_PER_CONTROLLER);
        end
        if (e_hit && !ehit_reg)
        begin
            ehit_action_reg <= eq_data_reg.action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_run_reg    <= 1'b0;
            ec_idx_reg    <= '0;
            eq_vld_reg    <= 1'b0;
            ehit_reg      <= 1'b0;
            ehit_idx_reg  <= '0;
            efree_reg     <= 1'b0;
            efree_idx_reg <= '0;
            cl_run_reg    <= 1'b0;
            cl_idx_reg    <= '0;
        end
        else
        begin
            eq_vld_reg <= ec_run_reg;
            if (cmd.entry_start)
            begin
                ec_run_reg <= 1'b1;
                ec_idx_reg <= '0;
                ehit_reg   <= 1'b0;
                efree_reg  <= 1'b0;
            end
            else
            begin
                if (ec_run_reg)
                begin
                    if (ec_idx_reg == LAST_ENT)
                    begin
                        ec_run_reg <= 1'b0;
                    end
                    else
                    begin
                        ec_idx_reg <= ec_idx_reg + 1'b1;
                    end
                end
                if (e_hit && !ehit_reg)
                begin
                    ehit_reg     <= 1'b1;
                    ehit_idx_reg <= eq_idx_reg;
                end
                if (eq_vld_reg && !eq_data_reg.used && !efree_reg)
                begin
                    efree_reg     <= 1'b1;
                    efree_idx_reg <= eq_idx_reg;
                end
            end
            if (cmd.clear_start)
            begin
                cl_run_reg <= 1'b1;
                cl_idx_reg <= '0;
            end
            else if (cl_run_reg)
            begin
                if (cl_idx_reg == LAST_ENT)
                begin
                    cl_run_reg <= 1'b0;
                end
                else
                begin
                    cl_idx_reg <= cl_idx_reg + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.resp || list_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            status_reg       <= cmd.resp_status;
            found_action_reg <= cmd.resp_action ? ehit_action_reg : 16'd0;
            listed_id_reg    <= 16'd0;
            id_valid_reg     <= 1'b0;
            last_reg         <= 1'b1;
        end
        else if (list_emit)
        begin
            status_reg       <= ST_OK;
            found_action_reg <= 16'd0;
            listed_id_reg    <= sq_id_reg;
            id_valid_reg     <= 1'b1;
            last_reg         <= list_last;
        end
    end

    assign valid        = valid_reg;
    assign status       = status_reg;
    assign found_action = found_action_reg;
    assign listed_id    = listed_id_reg;
    assign id_valid     = id_valid_reg;
    assign last         = last_reg;

    assign stat.op         = op_reg;
    assign stat.limit_zero = (limit_reg == 4'd0);
    assign stat.any_used   = |slot_used_reg;
    assign stat.slot_last  = sq_vld_reg && (sq_idx_reg == LAST_SLOT);
    assign stat.slot_hit   = shit_reg;
    assign stat.slot_free  = sfree_reg;
    assign stat.clear_last = cl_run_reg && (cl_idx_reg == LAST_ENT);
    assign stat.ent_last   = eq_vld_reg && (eq_idx_reg == LAST_ENT);
    assign stat.ent_hit    = ehit_reg;
    assign stat.ent_free   = efree_reg;

endmodule

@@ sv/controller_button_map_table.sv @@
// ----------------------------------------------------------------------------
// controller_button_map_table
// Two-level table: controller ids, each with its own button-to-action map.
//
// A request is taken when start is high and busy is low; op, ctrl_id,
// button, action and list_limit are sampled at that edge. Results come back
// on status, found_action, listed_id, id_valid and last, each shown for one
// cycle with valid high; the receiver takes every result as it comes.
// Add, map, get, remove and bad ops give one result; list gives one result
// per used id in slot order, up to list_limit and at most eight, the final
// one with last set; a zero limit or an empty table gives a single result.
// The controller slots are scanned one per cycle through a registered read,
// then the map of one controller one entry per cycle. Add scans the slots and
// then clears its new map one entry a cycle; map, get and remove scan the
// slots and then the map; list scans only the slots.
// One request is in flight at a time; busy stays high until it is done.
// Reset empties the controller table; maps need no clearing at reset since
// each one is cleared when its controller is added.
// ----------------------------------------------------------------------------
module controller_button_map_table
    import cbmt_pkg::*;
#(
    parameter int CONTROLLERS         = CTRL_DEFAULT,
    parameter int MAPS_PER_CONTROLLER = MAPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [15:0] ctrl_id,
    input  logic [7:0]  button,
    input  logic [15:0] action,
    input  logic [3:0]  list_limit,
    output logic        valid,
    output logic [1:0]  status,
    output logic [15:0] found_action,
    output logic [15:0] listed_id,
    output logic        id_valid,
    output logic        last
);

    cmd_t  cmd;
    stat_t stat;

    cbmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cbmt_datapath #(
        .CONTROLLERS         (CONTROLLERS),
        .MAPS_PER_CONTROLLER (MAPS_PER_CONTROLLER)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .ctrl_id      (ctrl_id),
        .button       (button),
        .action       (action),
        .list_limit   (list_limit),
        .valid        (valid),
        .status       (status),
        .found_action (found_action),
        .listed_id    (listed_id),
        .id_valid     (id_valid),
        .last         (last)
    );

endmodule

@@ sv/cbmt_checker.sv @@
// ----------------------------------------------------------------------------
// cbmt_port_checker
// Port-level checks on the controller button map table.
// ----------------------------------------------------------------------------
module cbmt_port_checker
    import cbmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        valid,
    input logic [1:0]  status,
    input logic [15:0] found_action,
    input logic        id_valid,
    input logic        last
);

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    // results without an id are always single
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !id_valid |-> last)
        else $error("single result without last");

    // listed ids are always good results
    a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && id_valid |-> status == ST_OK && found_action == 16'd0)
        else $error("listed id with bad status or action");

    // an action is only returned on success
    a_action_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && found_action != 16'd0 |-> status == ST_OK && !id_valid)
        else $error("action returned with failure status");

endmodule

bind controller_button_map_table cbmt_port_checker u_cbmt_checker (.*);

@@ verif/cbmt_checker.sv @@
// ----------------------------------------------------------------------------
// cbmt_checker
// Watches the request and result channels of the controller button map
// table. It keeps its own copy of the controller slots and button maps,
// works out the replies of every accepted request and compares each result
// strobe with the oldest reply still owed. It reports a failure count and the
// number of replies still outstanding.
// ----------------------------------------------------------------------------
module cbmt_checker
    import cbmt_pkg::*;
#(
    parameter int CONTROLLERS         = CTRL_DEFAULT,
    parameter int MAPS_PER_CONTROLLER = MAPS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  op,
    input  logic [15:0] ctrl_id,
    input  logic [7:0]  button,
    input  logic [15:0] action,
    input  logic [3:0]  list_limit,
    input  logic        valid,
    input  logic [1:0]  status,
    input  logic [15:0] found_action,
    input  logic [15:0] listed_id,
    input  logic        id_valid,
    input  logic        last,
    output int          errors,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = CONTROLLERS * MAPS_PER_CONTROLLER;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_action;
        logic [15:0] listed_id;
        logic        id_valid;
        logic        last;
    } reply_t;

    reply_t      reply_q [$];
    logic        slot_used  [CONTROLLERS];
    logic [15:0] slot_id    [CONTROLLERS];
    logic        ent_used   [ENTRIES];
    logic [7:0]  ent_button [ENTRIES];
    logic [15:0] ent_action [ENTRIES];

    function automatic int slot_of(input logic [15:0] id);
        for (int s = 0; s < CONTROLLERS; s++)
            if (slot_used[s] && slot_id[s] == id)
                return s;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int s = 0; s < CONTROLLERS; s++)
            if (!slot_used[s])
                return s;
        return -1;
    endfunction

    function automatic int entry_of(input int s, input logic [7:0] btn);
        for (int e = s * MAPS_PER_CONTROLLER; e < (s + 1) * MAPS_PER_CONTROLLER; e++)
            if (ent_used[e] && ent_button[e] == btn)
                return e;
        return -1;
    endfunction

    function automatic int free_entry(input int s);
        for (int e = s * MAPS_PER_CONTROLLER; e < (s + 1) * MAPS_PER_CONTROLLER; e++)
            if (!ent_used[e])
                return e;
        return -1;
    endfunction

    function automatic reply_t reply(input logic [1:0] st, input logic [15:0] act,
                                     input logic [15:0] id, input logic v,
                                     input logic l);
        reply_t r;
        r.status       = st;
        r.found_action = act;
        r.listed_id    = id;
        r.id_valid     = v;
        r.last         = l;
        return r;
    endfunction

    // applies one request to the table copy and queues the replies it owes
    task automatic table_op(input logic [2:0] o, input logic [15:0] id,
                            input logic [7:0] btn, input logic [15:0] act,
                            input logic [3:0] lim);
        int s;
        int e;
        int cap;
        int n;
        s = slot_of(id);
        case (o)
            OP_ADD:
            begin
                if (s >= 0)
                    reply_q.push_back(reply(ST_REFUSED, 0, 0, 0, 1));
                else
                begin
                    s = free_slot();
                    if (s < 0)
                        reply_q.push_back(reply(ST_FULL, 0, 0, 0, 1));
                    else
                    begin
                        slot_used[s] = 1'b1;
                        slot_id[s]   = id;
                        for (e = s * MAPS_PER_CONTROLLER; e < (s + 1) * MAPS_PER_CONTROLLER; e++)
                            ent_used[e] = 1'b0;
                        reply_q.push_back(reply(ST_OK, 0, 0, 0, 1));
                    end
                end
            end
            OP_MAP:
            begin
                if (s < 0)
                    reply_q.push_back(reply(ST_UNKNOWN, 0, 0, 0, 1));
                else
                begin
                    e = entry_of(s, btn);
                    if (e < 0)
                    begin
                        e = free_entry(s);
                        if (e >= 0)
                        begin
                            ent_used[e]   = 1'b1;
                            ent_button[e] = btn;
                        end
                    end
                    if (e < 0)
                        reply_q.push_back(reply(ST_REFUSED, 0, 0, 0, 1));
                    else
                    begin
                        ent_action[e] = act;
                        reply_q.push_back(reply(ST_OK, 0, 0, 0, 1));
                    end
                end
            end
            OP_GET, OP_REMOVE:
            begin
                if (s < 0)
                    reply_q.push_back(reply(ST_UNKNOWN, 0, 0, 0, 1));
                else
                begin
                    e = entry_of(s, btn);
                    if (e < 0)
                        reply_q.push_back(reply(ST_REFUSED, 0, 0, 0, 1));
                    else if (o == OP_GET)
                        reply_q.push_back(reply(ST_OK, ent_action[e], 0, 0, 1));
                    else
                    begin
                        ent_used[e] = 1'b0;
                        reply_q.push_back(reply(ST_OK, 0, 0, 0, 1));
                    end
                end
            end
            OP_LIST:
            begin
                if (lim == 0)
                    reply_q.push_back(reply(ST_UNKNOWN, 0, 0, 0, 1));
                else
                begin
                    cap = (lim > RESULT_CAP) ? RESULT_CAP : int'(lim);
                    n   = 0;
                    for (s = 0; s < CONTROLLERS; s++)
                        if (slot_used[s] && n < cap)
                        begin
                            reply_q.push_back(reply(ST_OK, 0, slot_id[s], 1, 0));
                            n++;
                        end
                    if (n == 0)
                        reply_q.push_back(reply(ST_OK, 0, 0, 0, 1));
                    else
                        reply_q[reply_q.size() - 1].last = 1'b1;
                end
            end
            default:
                reply_q.push_back(reply(ST_UNKNOWN, 0, 0, 0, 1));
        endcase
    endtask

    task automatic check_result();
        reply_t exp;
        if (reply_q.size() == 0)
        begin
            $error("unexpected result: status %0d listed_id %0h", status, listed_id);
            errors++;
        end
        else
        begin
            exp = reply_q.pop_front();
            if (status !== exp.status)
            begin
                $error("status: expected %0d, actual %0d", exp.status, status);
                errors++;
            end
            if (found_action !== exp.found_action)
            begin
                $error("found_action: expected %0h, actual %0h", exp.found_action, found_action);
                errors++;
            end
            if (listed_id !== exp.listed_id)
            begin
                $error("listed_id: expected %0h, actual %0h", exp.listed_id, listed_id);
                errors++;
            end
            if (id_valid !== exp.id_valid)
            begin
                $error("id_valid: expected %0b, actual %0b", exp.id_valid, id_valid);
                errors++;
            end
            if (last !== exp.last)
            begin
                $error("last: expected %0b, actual %0b", exp.last, last);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < CONTROLLERS; s++)
                slot_used[s] = 1'b0;
            for (int e = 0; e < ENTRIES; e++)
                ent_used[e] = 1'b0;
            reply_q.delete();
        end
        else
        begin
            // results first: a new request can be taken on the edge of a final result
            if (valid)
                check_result();
            if (start && !busy)
                table_op(op, ctrl_id, button, action, list_limit);
        end
        outstanding = reply_q.size();
    end

endmodule

@@ verif/controller_button_map_table_tb.sv @@
// ----------------------------------------------------------------------------
// controller_button_map_table_tb
// Drives requests into the controller button map table: a short directed
// pass over empty lists, unknown ids, duplicates, updates, removals, bad
// limits and unused op codes, then random traffic built mostly from a small
// pool of ids and buttons, with one run that fills a map to overflow. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module controller_button_map_table_tb
    import cbmt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [15:0] ctrl_id;
    logic [7:0]  button;
    logic [15:0] action;
    logic [3:0]  list_limit;
    logic        valid;
    logic [1:0]  status;
    logic [15:0] found_action;
    logic [15:0] listed_id;
    logic        id_valid;
    logic        last;
    int          errors;
    int          outstanding;

    logic [15:0] id_pool  [12];
    logic [7:0]  btn_pool [8];
    logic        quiet;

    controller_button_map_table i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .ctrl_id      (ctrl_id),
        .button       (button),
        .action       (action),
        .list_limit   (list_limit),
        .valid        (valid),
        .status       (status),
        .found_action (found_action),
        .listed_id    (listed_id),
        .id_valid     (id_valid),
        .last         (last)
    );

    cbmt_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .ctrl_id      (ctrl_id),
        .button       (button),
        .action       (action),
        .list_limit   (list_limit),
        .valid        (valid),
        .status       (status),
        .found_action (found_action),
        .listed_id    (listed_id),
        .id_valid     (id_valid),
        .last         (last),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("[controller_button_map_table] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic issue_request(input logic [2:0] o, input logic [15:0] id,
                                 input logic [7:0] btn, input logic [15:0] act,
                                 input logic [3:0] lim);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        ctrl_id    <= id;
        button     <= btn;
        action     <= act;
        list_limit <= lim;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic random_request();
        int          r;
        logic [2:0]  o;
        logic [15:0] id;
        logic [7:0]  btn;
        r   = $urandom_range(0, 99);
        id  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 11)];
        btn = ($urandom_range(0, 6) == 0) ? 8'($urandom) : btn_pool[$urandom_range(0, 7)];
        if (r < 80)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                o = OP_ADD;
            else if (r < 42)
                o = OP_MAP;
            else if (r < 67)
                o = OP_GET;
            else if (r < 82)
                o = OP_REMOVE;
            else
                o = OP_LIST;
            issue_request(o, id, btn, 16'($urandom), 4'($urandom_range(0, 15)));
        end
        else
            // noise, unused op codes included
            issue_request(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom),
                          16'($urandom), 4'($urandom));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_ADD;
        ctrl_id    = '0;
        button     = '0;
        action     = '0;
        list_limit = '0;
        quiet      = 1'b0;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int k = 2; k < 12; k++)
            id_pool[k] = 16'($urandom);
        btn_pool = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h80, 8'h55, 8'hAA, 8'h07};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, bad limit, unknown ids
        issue_request(OP_LIST, 16'h0, 8'h0, 16'h0, 4'd1);
        issue_request(OP_LIST, 16'h0, 8'h0, 16'h0, 4'd0);
        issue_request(OP_GET, 16'h0, 8'h0, 16'h0, 4'd0);
        issue_request(OP_MAP, 16'hFFFF, 8'hFF, 16'hFFFF, 4'd15);
        issue_request(OP_REMOVE, 16'h0, 8'h0, 16'h0, 4'd0);
        // adds, duplicate
        issue_request(OP_ADD, 16'h0000, 8'h0, 16'h0, 4'd0);
        issue_request(OP_ADD, 16'h0000, 8'hFF, 16'hFFFF, 4'd15);
        issue_request(OP_ADD, 16'hFFFF, 8'h0, 16'h0, 4'd0);
        // map, get, update, remove
        issue_request(OP_MAP, 16'h0000, 8'h00, 16'hFFFF, 4'd0);
        issue_request(OP_MAP, 16'hFFFF, 8'hFF, 16'h0000, 4'd0);
        issue_request(OP_GET, 16'h0000, 8'h00, 16'h0, 4'd0);
        issue_request(OP_GET, 16'hFFFF, 8'hFF, 16'h0, 4'd0);
        issue_request(OP_GET, 16'h0000, 8'hFF, 16'h0, 4'd0);
        issue_request(OP_MAP, 16'h0000, 8'h00, 16'h1234, 4'd0);
        issue_request(OP_GET, 16'h0000, 8'h00, 16'h0, 4'd0);
        issue_request(OP_REMOVE, 16'h0000, 8'h00, 16'h0, 4'd0);
        issue_request(OP_REMOVE, 16'h0000, 8'h00, 16'h0, 4'd0);
        issue_request(OP_GET, 16'h0000, 8'h00, 16'h0, 4'd0);
        // unused op codes
        issue_request(3'd5, 16'h0000, 8'h00, 16'h0, 4'd1);
        issue_request(3'd6, 16'hFFFF, 8'hFF, 16'hFFFF, 4'd8);
        issue_request(3'd7, 16'h0000, 8'h00, 16'h0, 4'd15);
        // list limits: one, eight, above eight
        issue_request(OP_LIST, 16'h0, 8'h0, 16'h0, 4'd1);
        issue_request(OP_LIST, 16'h0, 8'h0, 16'h0, 4'd8);
        issue_request(OP_LIST, 16'h0, 8'h0, 16'h0, 4'd15);

        for (int i = 0; i < 126; i++)
        begin
            quiet = (i % 50) >= 35;
            if (i == 80)
            begin
                // fill one map past its capacity
                quiet = 1'b1;
                for (int b = 0; b < 70; b++)
                    issue_request(OP_MAP, id_pool[0], 8'(b), 16'($urandom), 4'($urandom));
                quiet = 1'b0;
            end
            random_request();
        end

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("[controller_button_map_table] OK");
        else
            $display("[controller_button_map_table] ERROR");
        $finish;
    end

endmodule
